[design/ghash_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// GHASH package
// Shared widths, constants, control codes and types for the GHASH block.
// ----------------------------------------------------------------------------
package ghash_pkg;

  localparam int unsigned BlkW   = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned BytesW = 5;
  localparam int unsigned NBytes = BlkW / 8;
  localparam int unsigned StepW  = $clog2(BlkW);

  // Reduction byte of the field polynomial, applied at the leading byte.
  localparam logic [7:0] GfReduce = 8'he1;

  // Configuration register indexes.
  localparam logic CfgHHi = 1'b0;
  localparam logic CfgHLo = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_LEN,
    ST_EMIT
  } ghash_state_e;

  // Status of the serial multiplier as seen by the controller.
  typedef struct packed {
    logic done;
  } gfmul_status_t;

endpackage : ghash_pkg
`default_nettype wire

[design/ghash_gfmul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// GHASH bit-serial multiplier
// Multiplies X by H in GF(2^128), GCM bit order, one bit of X per cycle.
// ----------------------------------------------------------------------------
module ghash_gfmul import ghash_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [BlkW-1:0]    x_i,
  input  wire logic [BlkW-1:0]    h_i,
  output gfmul_status_t           status_o,
  output logic      [BlkW-1:0]    z_o
);

  localparam logic [StepW-1:0] LastStep = StepW'(BlkW - 1);

  logic [BlkW-1:0]  x_q, x_d, v_q, v_d, z_q, z_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d    = x_q;
    v_d    = v_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      v_d    = h_i;
      z_d    = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The leading bit of X selects whether the current multiple of H is added.
      if (x_q[BlkW-1]) begin
        z_d = z_q ^ v_q;
      end
      v_d = v_q >> 1;
      if (v_q[0]) begin
        v_d[BlkW-1 -: 8] = v_d[BlkW-1 -: 8] ^ GfReduce;
      end
      x_d    = x_q << 1;
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    v_q <= v_d;
    z_q <= z_d;
  end

  assign status_o.done = done_q;
  assign z_o           = z_q;

endmodule : ghash_gfmul
`default_nettype wire

[design/ghash_authenticator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// GHASH authenticator
// Folds additional data and ciphertext blocks into the GCM hash and emits it.
// ----------------------------------------------------------------------------
// Each transaction carries one 128-bit block with its count of leading valid
// bytes (counts above 16 act as 16; bytes past the count are zeroed). A block
// with a nonzero count is XORed into the accumulator and multiplied by H in a
// bit-serial GF(2^128) multiplier that consumes one bit of the operand per
// cycle. The bit counts of additional data and ciphertext are kept modulo
// 2^64. A transaction with last set also absorbs the length block
// (additional-data bits, then text bits) through a second multiply, and then
// loads the hash into the output register and clears the accumulator and
// counts. The block takes one item at a time: in_stall_o is high from
// acceptance until the multiply work of that item is done and, for a last
// item, its hash is loaded into the output register. The output register
// decouples the result side, so the next item is taken while a hash still
// waits; only a second hash waits for it. H is to be written through the
// configuration port only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module ghash_authenticator import ghash_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [HalfW-1:0]  cfg_wdata_i,
  // Input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [HalfW-1:0]  block_hi_i,
  input  wire logic [HalfW-1:0]  block_lo_i,
  input  wire logic [BytesW-1:0] valid_bytes_i,
  input  wire logic              is_text_i,
  input  wire logic              last_i,
  // Output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [HalfW-1:0]  hash_hi_o,
  output logic      [HalfW-1:0]  hash_lo_o
);

  localparam logic [BytesW-1:0] FullCount = BytesW'(NBytes);

  ghash_state_e  state_q, state_d;
  logic [HalfW-1:0] h_hi_q, h_lo_q;
  logic [BlkW-1:0]  acc_q, acc_d;
  logic [HalfW-1:0] aad_bits_q, aad_bits_d, text_bits_q, text_bits_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [BlkW-1:0]  hash_q, hash_d;

  logic             in_accept;
  logic             out_free;
  logic [BytesW-1:0] n_sat;
  logic [BlkW-1:0]  block_raw, block_masked;
  logic [HalfW-1:0] n_bits;
  logic             mul_start;
  logic [BlkW-1:0]  mul_x, mul_z;
  gfmul_status_t    mul_status;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  // The output register can take a new hash when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Saturate the byte count and zero bytes past it; byte 0 sits on top.
  always_comb begin
    n_sat = (valid_bytes_i > FullCount) ? FullCount : valid_bytes_i;
    block_raw = {block_hi_i, block_lo_i};
    for (int j = 0; j < NBytes; j++) begin
      block_masked[BlkW-1-8*j -: 8] =
        (BytesW'(j) < n_sat) ? block_raw[BlkW-1-8*j -: 8] : 8'h00;
    end
    n_bits = {{(HalfW-BytesW-3){1'b0}}, n_sat, 3'b000};
  end

  // H registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_hi_q <= '0;
      h_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHHi:  h_hi_q <= cfg_wdata_i;
        CfgHLo:  h_lo_q <= cfg_wdata_i;
        default: h_hi_q <= h_hi_q;
      endcase
    end
  end

  // Controller: sequences the data multiply, the length multiply and the
  // hand-off of the hash to the output register.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    aad_bits_d  = aad_bits_q;
    text_bits_d = text_bits_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    hash_d      = hash_q;
    mul_start   = 1'b0;
    mul_x       = acc_q ^ block_masked;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          last_d = last_i;
          if (n_sat != '0) begin
            if (is_text_i) begin
              text_bits_d = text_bits_q + n_bits;
            end else begin
              aad_bits_d = aad_bits_q + n_bits;
            end
            mul_start = 1'b1;
            mul_x     = acc_q ^ block_masked;
            state_d   = ST_DATA;
          end else if (last_i) begin
            // Empty last block: go straight to the length block.
            mul_start = 1'b1;
            mul_x     = acc_q ^ {aad_bits_q, text_bits_q};
            state_d   = ST_LEN;
          end
        end
      end
      ST_DATA: begin
        if (mul_status.done) begin
          acc_d = mul_z;
          if (last_q) begin
            mul_start = 1'b1;
            mul_x     = mul_z ^ {aad_bits_q, text_bits_q};
            state_d   = ST_LEN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LEN: begin
        if (mul_status.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The multiplier keeps its product until the next start.
        if (out_free) begin
          hash_d      = mul_z;
          out_valid_d = 1'b1;
          acc_d       = '0;
          aad_bits_d  = '0;
          text_bits_d = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      aad_bits_q  <= '0;
      text_bits_q <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      aad_bits_q  <= aad_bits_d;
      text_bits_q <= text_bits_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  ghash_gfmul u_gfmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .x_i      (mul_x),
    .h_i      ({h_hi_q, h_lo_q}),
    .status_o (mul_status),
    .z_o      (mul_z)
  );

  assign out_valid_o = out_valid_q;
  assign hash_hi_o   = hash_q[BlkW-1 -: HalfW];
  assign hash_lo_o   = hash_q[HalfW-1:0];

endmodule : ghash_authenticator
`default_nettype wire

[verif/ghash_authenticator_tb.sv]
// ----------------------------------------------------------------------------
// GHASH authenticator testbench
// Drives additional-data and ciphertext blocks into the block under several
// hash subkeys. A scoreboard class predicts each hash with its own
// bit-serial GF(2^128) multiply and compares every hash the block returns.
// ----------------------------------------------------------------------------
module ghash_authenticator_tb import ghash_pkg::*; ;

  // Subkeys used phase by phase. Phase 4 replaces its entry with a random key.
  // The first is the subkey of the all-zero AES key, the fourth is the
  // multiplicative identity in GCM bit order.
  localparam bit [63:0] KeyHi [6] = '{64'h66e94bd4ef8a2c3b, 64'hffffffffffffffff,
                                      64'h0, 64'h8000000000000000, 64'h0, 64'h0};
  localparam bit [63:0] KeyLo [6] = '{64'h884cfa59ca342b2e, 64'hffffffffffffffff,
                                      64'h0, 64'h0, 64'h0, 64'h1};
  // Counted blocks per phase in the random part.
  localparam int unsigned PhaseBlocks [6] = '{130, 150, 100, 100, 250, 150};
  // The receiver holds off once, after this many hashes, for this many cycles.
  localparam int unsigned HoldAfter  = 12;
  localparam int unsigned HoldCycles = 2000;
  // Cycles to let pass before a subkey write: a last transaction runs two
  // multiplies, so this covers any transaction still in flight.
  localparam int unsigned SettleCycles = 300;

  // Predicts the hash of each message and checks the hashes the block emits.
  class ghash_scoreboard;
    bit [127:0]  subkey;
    bit [127:0]  acc;
    bit [63:0]   aad_bits;
    bit [63:0]   text_bits;
    bit [127:0]  hash_q[$];
    int unsigned errors;
    int unsigned hashes_checked;

    function new();
      subkey         = '0;
      acc            = '0;
      aad_bits       = '0;
      text_bits      = '0;
      errors         = 0;
      hashes_checked = 0;
    endfunction

    function void set_subkey(bit [63:0] hi, bit [63:0] lo);
      subkey = {hi, lo};
    endfunction

    // acc = (acc ^ x) * H. Bit 127 of a vector is the first bit in GCM order,
    // so a right shift multiplies by x and the reduction lands on the top byte.
    function void fold(bit [127:0] x);
      bit [127:0] y;
      bit [127:0] z;
      bit [127:0] v;
      bit         lsb;
      y = acc ^ x;
      z = '0;
      v = subkey;
      for (int i = 127; i >= 0; i--) begin
        if (y[i]) z ^= v;
        lsb = v[0];
        v   = v >> 1;
        if (lsb) v[127:120] ^= GfReduce;
      end
      acc = z;
    endfunction

    // Called for every accepted transaction.
    function void note_block(bit [63:0] hi, bit [63:0] lo, bit [4:0] count,
                             bit text, bit fin);
      bit [127:0]  mask;
      int unsigned n;
      n = (count > 16) ? 16 : count;
      if (n != 0) begin
        mask = {128{1'b1}} << (8 * (16 - n));
        fold({hi, lo} & mask);
        if (text) text_bits += 64'(8 * n);
        else aad_bits += 64'(8 * n);
      end
      if (fin) begin
        fold({aad_bits, text_bits});
        hash_q.push_back(acc);
        acc       = '0;
        aad_bits  = '0;
        text_bits = '0;
      end
    endfunction

    // Called for every accepted result transaction.
    function void check_hash(logic [63:0] hi, logic [63:0] lo);
      bit [127:0] want;
      if (hash_q.size() == 0) begin
        $error("hash %h_%h arrived with no message outstanding", hi, lo);
        errors++;
      end else begin
        want = hash_q.pop_front();
        hashes_checked++;
        if (hi !== want[127:64]) begin
          $error("hash_hi mismatch: expected %h, actual %h", want[127:64], hi);
          errors++;
        end
        if (lo !== want[63:0]) begin
          $error("hash_lo mismatch: expected %h, actual %h", want[63:0], lo);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return hash_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [HalfW-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [HalfW-1:0]  block_hi_i;
  logic [HalfW-1:0]  block_lo_i;
  logic [BytesW-1:0] valid_bytes_i;
  logic              is_text_i;
  logic              last_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [HalfW-1:0]  hash_hi_o;
  logic [HalfW-1:0]  hash_lo_o;

  ghash_scoreboard sb;
  int unsigned     blocks_sent;
  int unsigned     hashes_taken;
  int unsigned     hold_left;
  // When set, the sender offers back to back and the receiver stalls only for the hold-off.
  bit              tx_steady;
  bit              rx_steady;

  ghash_authenticator uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly full blocks; otherwise any count, including zero and the
  // oversized counts that act as sixteen.
  function automatic bit [4:0] pick_count();
    return ($urandom_range(0, 1) != 0) ? 5'd16 : 5'($urandom_range(0, 31));
  endfunction

  // Offers one transaction, optionally after a random gap, and returns at the
  // clock edge that accepts it. Valid stays high so that the next call can
  // keep offering without a dead cycle.
  task automatic send_block(input bit [63:0] hi, input bit [63:0] lo,
                            input bit [4:0] count, input bit text, input bit fin);
    int unsigned gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 260);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    block_hi_i    <= hi;
    block_lo_i    <= lo;
    valid_bytes_i <= count;
    is_text_i     <= text;
    last_i        <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_block(hi, lo, count, text, fin);
    // A transaction with no data and no last flag is a no-op for the block.
    if (count != 0 || fin) blocks_sent++;
  endtask

  // Stops offering, waits until every predicted hash has been taken, and
  // then lets tail more cycles pass.
  task automatic quiesce(input int unsigned tail);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  // Writes both halves of H on consecutive edges; the block is idle here.
  task automatic program_key(input bit [63:0] hi, input bit [63:0] lo);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgHHi;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_idx_i   <= CfgHLo;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_subkey(hi, lo);
  endtask

  // Result side. Outputs are sampled right after the edge, so they hold the
  // values the block presented at that edge. After a fixed number of hashes
  // the receiver stalls for a long stretch, counted here, while the sender
  // keeps going; the output register fills and the block stalls its input.
  initial begin
    hashes_taken = 0;
    hold_left    = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_hash(hash_hi_o, hash_lo_o);
        hashes_taken++;
        if (hashes_taken == HoldAfter) hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  initial begin
    bit [63:0]   key_hi;
    bit [63:0]   key_lo;
    int unsigned target;
    int unsigned n_aad;
    int unsigned n_txt;

    sb            = new();
    blocks_sent   = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgHHi;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    block_hi_i    = '0;
    block_lo_i    = '0;
    valid_bytes_i = '0;
    is_text_i     = 1'b0;
    last_i        = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < 6; p++) begin
      // Subkey changes happen only with nothing in flight.
      if (p != 0) quiesce(SettleCycles);
      key_hi = KeyHi[p];
      key_lo = KeyLo[p];
      if (p == 4) begin
        key_hi = rand64();
        key_lo = rand64();
      end
      program_key(key_hi, key_lo);
      // Phase 1 runs with no random gaps on either side.
      tx_steady = (p == 1);
      rx_steady = (p == 1);

      if (p == 0) begin
        // An empty message hashes only the all-zero length block.
        send_block(64'h0, 64'h0, 5'd0, 1'b0, 1'b1);
        // Full data and text blocks, then a last transaction without data.
        send_block('1, '1, 5'd16, 1'b0, 1'b0);
        send_block(64'h0388dace60b6a392, 64'hf328c2b971b2fe78, 5'd16, 1'b1, 1'b0);
        send_block('1, '1, 5'd0, 1'b1, 1'b1);
        // Partial blocks at both ends of each half, additional data arriving
        // after ciphertext, and a last transaction that carries data.
        send_block('1, '1, 5'd1, 1'b0, 1'b0);
        send_block('1, '1, 5'd15, 1'b1, 1'b0);
        send_block('1, '1, 5'd8, 1'b1, 1'b0);
        send_block(rand64(), rand64(), 5'd9, 1'b0, 1'b0);
        send_block(rand64(), rand64(), 5'd7, 1'b1, 1'b1);
        // Oversized counts act as a full block; a zero count without last
        // is ignored.
        send_block('1, '1, 5'd17, 1'b0, 1'b0);
        send_block(rand64(), rand64(), 5'd31, 1'b1, 1'b0);
        send_block(rand64(), rand64(), 5'd0, 1'b1, 1'b0);
        send_block(rand64(), rand64(), 5'd16, 1'b0, 1'b1);
        // Alternating bit patterns and an all-zero block.
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd16, 1'b1, 1'b1);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd0, 1'b0, 1'b0);
        send_block(64'h0, 64'h0, 5'd16, 1'b1, 1'b1);
      end

      // Random part: mostly well-formed messages (data blocks, then text
      // blocks, then a last transaction), the rest arbitrary transactions
      // that may leave a message open across phases.
      target = blocks_sent + PhaseBlocks[p];
      while (blocks_sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          n_aad = $urandom_range(0, 3);
          n_txt = $urandom_range(0, 4);
          repeat (n_aad) send_block(rand64(), rand64(), pick_count(), 1'b0, 1'b0);
          repeat (n_txt) send_block(rand64(), rand64(), pick_count(), 1'b1, 1'b0);
          send_block(rand64(), rand64(),
                     ($urandom_range(0, 1) != 0) ? 5'd0 : pick_count(),
                     (n_txt != 0) || ($urandom_range(0, 1) != 0), 1'b1);
        end else begin
          send_block(rand64(), rand64(), 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        // Now and then the sender pauses until every hash is back.
        if ($urandom_range(0, 49) == 0) quiesce(0);
      end
    end

    quiesce(SettleCycles);
    if (sb.pending() != 0) begin
      $error("%0d predicted hashes never arrived", sb.pending());
      sb.errors++;
    end
    $display("Summary: %0d data and last transactions under six hash subkeys, %0d hashes compared.",
             blocks_sent, sb.hashes_checked);
    $display("Summary: included partial, empty and oversized counts, a long output hold-off.");
    if (sb.errors == 0) begin
      $display("ghash_authenticator_tb: clean");
    end else begin
      $display("ghash_authenticator_tb: errors");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #30000000;
    $display("Watchdog expired before the run completed.");
    $display("ghash_authenticator_tb: errors");
    $finish;
  end

endmodule
